>>> rtl/core/fpqs_pkg.sv
// ----------------------------------------------------------------------------
// Five-point quadratic smoother package
// Shared constants, the smoothing coefficient table and the control structs
// passed between the smoother stages.
// ----------------------------------------------------------------------------
package fpqs_pkg;

    // Taps of the fit window and depth of the sample history.
    localparam int N_TAPS    = 5;
    localparam int WIN_DEPTH = 4;

    // Frame position count saturates here once the window is full.
    localparam int FULL_COUNT = 5;

    // Fit rows: the two leading end rows, the centered row, the two trailing end rows.
    localparam int FIRST_ROW  = 0;
    localparam int CENTER_ROW = 2;
    localparam int LAST_ROW   = 4;

    // All rows share the normalizer 35; 17 is half of it for round to nearest.
    localparam int DIVISOR  = 35;
    localparam int HALF_DIV = 17;

    // The largest row magnitude sum is 51, so a weighted sum grows by at most
    // five bits of magnitude, six bits with the sign.
    localparam int COEF_W     = 6;
    localparam int MAG_GROWTH = 5;
    localparam int ACC_GROWTH = 6;

    typedef logic [2:0] t_row;
    typedef logic signed [COEF_W-1:0] t_coef;

    // Per-result control that travels alongside the data.
    typedef struct packed {
        logic last;
        logic short_frm;
    } t_tag;

    localparam t_coef COEF [N_TAPS][N_TAPS] = '{
        '{ 6'sd31,  6'sd9,  -6'sd3, -6'sd5,  6'sd3  },
        '{ 6'sd9,   6'sd13,  6'sd12, 6'sd6, -6'sd5  },
        '{-6'sd3,   6'sd12,  6'sd17, 6'sd12, -6'sd3 },
        '{-6'sd5,   6'sd6,   6'sd12, 6'sd13,  6'sd9 },
        '{ 6'sd3,  -6'sd5,  -6'sd3,  6'sd9,   6'sd31}
    };

    function automatic t_coef coef_at(t_row row, int tap);
        t_coef c;
        c = '0;
        if (row < t_row'(N_TAPS)) begin
            c = COEF[row][tap];
        end
        return c;
    endfunction

endpackage

>>> rtl/core/fpqs_in_if.sv
// ----------------------------------------------------------------------------
// Smoother sample channel
// Valid/ready channel that carries one input sample word and its frame flag.
// ----------------------------------------------------------------------------
interface fpqs_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           frame_end;

    modport source (output valid, sample, frame_end, input ready);
    modport sink   (input valid, sample, frame_end, output ready);
endinterface

>>> rtl/core/fpqs_out_if.sv
// ----------------------------------------------------------------------------
// Smoother result channel
// Valid/ready channel that carries one smoothed result word and its flags.
// ----------------------------------------------------------------------------
interface fpqs_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] smoothed;
    logic                           result_last;
    logic                           short_frame;

    modport source (output valid, smoothed, result_last, short_frame, input ready);
    modport sink   (input valid, smoothed, result_last, short_frame, output ready);
endinterface

>>> rtl/core/fpqs_framer.sv
// ----------------------------------------------------------------------------
// Smoother frame tracker
// Keeps the sample history and frame position; each word that finds the window full or
// ends a frame becomes a job issuing one result per cycle while the next stage is ready.
// ----------------------------------------------------------------------------
module fpqs_framer #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_valid,
    output logic                                             o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]                   i_sample,
    input  logic                                             i_frame_end,
    output logic                                             o_iss_valid,
    input  logic                                             i_iss_ready,
    output logic [fpqs_pkg::N_TAPS-1:0][SAMPLE_WIDTH-1:0]    o_iss_v,
    output fpqs_pkg::t_row                                   o_iss_row,
    output fpqs_pkg::t_tag                                   o_iss_tag
);
    localparam int WD = fpqs_pkg::WIN_DEPTH;
    localparam logic [2:0] CNT_FULL  = 3'(fpqs_pkg::FULL_COUNT);
    localparam logic [2:0] CNT_WIN   = 3'(fpqs_pkg::WIN_DEPTH);
    localparam fpqs_pkg::t_row ROW_FIRST  = fpqs_pkg::t_row'(fpqs_pkg::FIRST_ROW);
    localparam fpqs_pkg::t_row ROW_CENTER = fpqs_pkg::t_row'(fpqs_pkg::CENTER_ROW);
    localparam fpqs_pkg::t_row ROW_LAST   = fpqs_pkg::t_row'(fpqs_pkg::LAST_ROW);

    logic [WD-1:0][SAMPLE_WIDTH-1:0]               r_win, n_win;
    logic [2:0]                                    r_cnt, n_cnt;
    logic                                          r_job_vld, n_job_vld;
    fpqs_pkg::t_row                                r_job_idx, n_job_idx;
    fpqs_pkg::t_row                                r_job_hi, n_job_hi;
    logic                                          r_job_short, n_job_short;
    logic                                          r_job_fend, n_job_fend;
    logic [fpqs_pkg::N_TAPS-1:0][SAMPLE_WIDTH-1:0] r_job_v, n_job_v;

    logic iss_last;
    logic iss_done;
    logic accept;
    logic partial;

    assign iss_last = (r_job_idx == r_job_hi);
    assign iss_done = r_job_vld & i_iss_ready & iss_last;
    // A new word enters as soon as the current job hands over its final result.
    assign o_ready  = !r_job_vld | iss_done;
    assign accept   = i_valid & o_ready;
    assign partial  = (r_cnt < CNT_WIN);

    always_comb begin
        n_win       = r_win;
        n_cnt       = r_cnt;
        n_job_vld   = r_job_vld;
        n_job_idx   = r_job_idx;
        n_job_hi    = r_job_hi;
        n_job_short = r_job_short;
        n_job_fend  = r_job_fend;
        n_job_v     = r_job_v;

        if (r_job_vld && i_iss_ready) begin
            if (iss_last) begin
                n_job_vld = 1'b0;
            end else begin
                n_job_idx = r_job_idx + fpqs_pkg::t_row'(1);
            end
        end

        if (accept) begin
            if (partial && !i_frame_end) begin
                n_win = {i_sample, r_win[WD-1:1]};
                n_cnt = r_cnt + 3'd1;
            end else begin
                n_job_vld   = 1'b1;
                n_job_v     = {i_sample, r_win};
                n_job_fend  = i_frame_end;
                n_job_short = partial;
                if (partial) begin
                    // Short frame: replay the samples of this frame unchanged.
                    n_job_idx = fpqs_pkg::t_row'(CNT_WIN - r_cnt);
                    n_job_hi  = ROW_LAST;
                end else begin
                    n_job_idx = (r_cnt == CNT_WIN) ? ROW_FIRST : ROW_CENTER;
                    n_job_hi  = i_frame_end ? ROW_LAST : ROW_CENTER;
                end
                if (i_frame_end) begin
                    n_cnt = 3'd0;
                end else begin
                    n_win = {i_sample, r_win[WD-1:1]};
                    n_cnt = CNT_FULL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_cnt     <= 3'd0;
            r_job_vld <= 1'b0;
        end else begin
            r_win     <= n_win;
            r_cnt     <= n_cnt;
            r_job_vld <= n_job_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job_idx   <= n_job_idx;
        r_job_hi    <= n_job_hi;
        r_job_short <= n_job_short;
        r_job_fend  <= n_job_fend;
        r_job_v     <= n_job_v;
    end

    assign o_iss_valid         = r_job_vld;
    assign o_iss_v             = r_job_v;
    assign o_iss_row           = r_job_idx;
    assign o_iss_tag.last      = r_job_fend & iss_last;
    assign o_iss_tag.short_frm = r_job_short;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_vld |-> (r_job_idx <= r_job_hi))
        else $error("result index ran past the end of its job");

    a_short_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_vld && r_job_short) |-> (r_job_fend && r_job_hi == ROW_LAST))
        else $error("short frame job without frame end");

    a_open_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_vld && !r_job_short && !r_job_fend) |-> (r_cnt == CNT_FULL))
        else $error("frame position lost while a frame is open");
endmodule

>>> rtl/core/fpqs_mac.sv
// ----------------------------------------------------------------------------
// Smoother weighted sum stage
// Forms the five-tap weighted sum for the selected fit row and registers it
// together with the raw sample used on short frames.
// ----------------------------------------------------------------------------
module fpqs_mac #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [fpqs_pkg::N_TAPS-1:0][SAMPLE_WIDTH-1:0] i_v,
    input  fpqs_pkg::t_row                                i_row,
    input  fpqs_pkg::t_tag                                i_tag,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic signed [SAMPLE_WIDTH+fpqs_pkg::ACC_GROWTH-1:0] o_sum,
    output logic [SAMPLE_WIDTH-1:0]                       o_raw,
    output fpqs_pkg::t_tag                                o_tag
);
    localparam int SUM_W = SAMPLE_WIDTH + fpqs_pkg::ACC_GROWTH;

    logic                     r_vld;
    logic signed [SUM_W-1:0]  r_sum;
    logic [SAMPLE_WIDTH-1:0]  r_raw;
    fpqs_pkg::t_tag           r_tag;
    logic signed [SUM_W-1:0]  sum_c;

    always_comb begin
        logic signed [SUM_W-1:0] prod;
        sum_c = '0;
        for (int k = 0; k < fpqs_pkg::N_TAPS; k++) begin
            prod  = SUM_W'($signed(i_v[k])) * SUM_W'(fpqs_pkg::coef_at(i_row, k));
            sum_c = sum_c + prod;
        end
    end

    assign o_ready = !r_vld | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_sum <= sum_c;
            r_raw <= i_v[i_row];
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_vld;
    assign o_sum   = r_sum;
    assign o_raw   = r_raw;
    assign o_tag   = r_tag;
endmodule

>>> rtl/core/fpqs_div35.sv
// ----------------------------------------------------------------------------
// Smoother normalizer
// Divides the weighted sum by 35 with round to nearest (ties away from zero)
// and saturates, using a split reciprocal product and a one-step correction.
// ----------------------------------------------------------------------------
module fpqs_div35 #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_valid,
    output logic                                                o_ready,
    input  logic signed [SAMPLE_WIDTH+fpqs_pkg::ACC_GROWTH-1:0] i_sum,
    input  logic [SAMPLE_WIDTH-1:0]                             i_raw,
    input  fpqs_pkg::t_tag                                      i_tag,
    output logic                                                o_valid,
    input  logic                                                i_ready,
    output logic [SAMPLE_WIDTH-1:0]                             o_value,
    output fpqs_pkg::t_tag                                      o_tag
);
    localparam int SUM_W  = SAMPLE_WIDTH + fpqs_pkg::ACC_GROWTH;
    localparam int MAG_W  = SAMPLE_WIDTH + fpqs_pkg::MAG_GROWTH;
    localparam int LO_W   = MAG_W / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PROD_W = MAG_W + SAMPLE_WIDTH;

    // floor(2^MAG_W / 35) fits in SAMPLE_WIDTH bits.
    localparam logic [63:0] RECIP64 = (64'd1 << MAG_W) / 64'(fpqs_pkg::DIVISOR);
    localparam logic [SAMPLE_WIDTH-1:0] RECIP = RECIP64[SAMPLE_WIDTH-1:0];
    // Any magnitude at or above this saturates, so larger ones are clipped to it.
    localparam logic [63:0] CLAMP64 =
        64'(fpqs_pkg::DIVISOR) * ((64'd1 << (SAMPLE_WIDTH - 1)) + 64'd1) - 64'd1;
    localparam logic [MAG_W-1:0] CLAMP   = CLAMP64[MAG_W-1:0];
    localparam logic [MAG_W-1:0] DIV_M   = MAG_W'(fpqs_pkg::DIVISOR);
    localparam logic [MAG_W-1:0] DIV2_M  = MAG_W'(2 * fpqs_pkg::DIVISOR);
    localparam logic [SUM_W-1:0] HALF_S  = SUM_W'(fpqs_pkg::HALF_DIV);
    localparam logic [SAMPLE_WIDTH-1:0] POS_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] Q_LIMIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic                          r_s2_vld;
    logic [HI_W+SAMPLE_WIDTH-1:0]  r_s2_pph;
    logic [LO_W+SAMPLE_WIDTH-1:0]  r_s2_ppl;
    logic [MAG_W-1:0]              r_s2_mag;
    logic                          r_s2_neg;
    logic [SAMPLE_WIDTH-1:0]       r_s2_raw;
    fpqs_pkg::t_tag                r_s2_tag;

    logic                          r_s3_vld;
    logic [SAMPLE_WIDTH-1:0]       r_s3_q;
    logic [MAG_W-1:0]              r_s3_mag;
    logic                          r_s3_neg;
    logic [SAMPLE_WIDTH-1:0]       r_s3_raw;
    fpqs_pkg::t_tag                r_s3_tag;

    logic                          r_out_vld;
    logic [SAMPLE_WIDTH-1:0]       r_out_val;
    fpqs_pkg::t_tag                r_out_tag;

    logic                          rdy_out, rdy_s3;
    logic                          neg_c;
    logic [SUM_W-1:0]              abs_c, mag_full_c;
    logic [MAG_W-1:0]              mag_c;
    logic [HI_W+SAMPLE_WIDTH-1:0]  pph_c;
    logic [LO_W+SAMPLE_WIDTH-1:0]  ppl_c;
    logic [PROD_W-1:0]             prod_c;
    logic [MAG_W-1:0]              rem_c;
    logic [SAMPLE_WIDTH-1:0]       q_fix_c, sat_c;

    assign rdy_out = !r_out_vld | i_ready;
    assign rdy_s3  = !r_s3_vld | rdy_out;
    assign o_ready = !r_s2_vld | rdy_s3;

    // Magnitude plus half the divisor, clipped, times the reciprocal in two halves.
    always_comb begin
        neg_c      = i_sum[SUM_W-1];
        abs_c      = neg_c ? SUM_W'(-i_sum) : SUM_W'(i_sum);
        mag_full_c = abs_c + HALF_S;
        mag_c      = (mag_full_c > SUM_W'(CLAMP)) ? CLAMP : mag_full_c[MAG_W-1:0];
        pph_c      = (HI_W+SAMPLE_WIDTH)'(mag_c[MAG_W-1:LO_W]) *
                     (HI_W+SAMPLE_WIDTH)'(RECIP);
        ppl_c      = (LO_W+SAMPLE_WIDTH)'(mag_c[LO_W-1:0]) *
                     (LO_W+SAMPLE_WIDTH)'(RECIP);
    end

    assign prod_c = (PROD_W'(r_s2_pph) << LO_W) + PROD_W'(r_s2_ppl);

    // The reciprocal estimate is at most one below the true quotient.
    always_comb begin
        rem_c   = r_s3_mag - MAG_W'(r_s3_q) * DIV_M;
        q_fix_c = (rem_c >= DIV_M) ? r_s3_q + SAMPLE_WIDTH'(1) : r_s3_q;
        if (r_s3_neg) begin
            sat_c = SAMPLE_WIDTH'(-q_fix_c);
        end else begin
            sat_c = q_fix_c[SAMPLE_WIDTH-1] ? POS_MAX : q_fix_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s2_vld <= i_valid;
            end
            if (rdy_s3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (rdy_out) begin
                r_out_vld <= r_s3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_s2_pph <= pph_c;
            r_s2_ppl <= ppl_c;
            r_s2_mag <= mag_c;
            r_s2_neg <= neg_c;
            r_s2_raw <= i_raw;
            r_s2_tag <= i_tag;
        end
        if (rdy_s3) begin
            r_s3_q   <= prod_c[PROD_W-1:MAG_W];
            r_s3_mag <= r_s2_mag;
            r_s3_neg <= r_s2_neg;
            r_s3_raw <= r_s2_raw;
            r_s3_tag <= r_s2_tag;
        end
        if (rdy_out) begin
            r_out_val <= r_s3_tag.short_frm ? r_s3_raw : sat_c;
            r_out_tag <= r_s3_tag;
        end
    end

    assign o_valid = r_out_vld;
    assign o_value = r_out_val;
    assign o_tag   = r_out_tag;

    a_estimate_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld |-> (rem_c < DIV2_M))
        else $error("reciprocal quotient estimate off by more than one");

    a_quotient_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld |-> (q_fix_c <= Q_LIMIT))
        else $error("corrected quotient beyond the clipped range");
endmodule

>>> rtl/core/five_point_quadratic_smoother.sv
// ----------------------------------------------------------------------------
// Five-point quadratic smoother
// Savitzky-Golay 5-point, degree-2 smoothing of framed signed samples.
// ----------------------------------------------------------------------------
// Samples enter one word per cycle on the input channel while it is ready,
// frame_end marking the last of a frame. Results lag by two samples: the fifth
// sample yields three results (both leading end-point rows and the first
// centered one), each later sample one centered result, and a frame-ending
// sample also the two trailing end-point results. A frame of one to four
// samples comes back unchanged with short_frame set; each result of a longer
// frame is the weighted sum over original samples divided by 35, rounded to
// nearest with ties away from zero and saturated. The block sustains one
// sample per cycle inside a frame while the output is ready; a sample that
// yields several results holds the input until its last result has left the
// issue register, where results leave one per cycle while the next stage is
// ready (the end of a short frame yields as many results as the frame had
// samples). An issued result reaches the output register through the weighted
// sum, reciprocal product and quotient correction stages. Each stage advances
// whenever the next register is free, so empty slots close up and a stalled
// output holds back upstream stages only once the registers before it are full.
module five_point_quadratic_smoother #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fpqs_in_if.sink        i_in,
    fpqs_out_if.source     o_out
);
    localparam int SUM_W = SAMPLE_WIDTH + fpqs_pkg::ACC_GROWTH;

    logic                                          iss_valid, iss_ready;
    logic [fpqs_pkg::N_TAPS-1:0][SAMPLE_WIDTH-1:0] iss_v;
    fpqs_pkg::t_row                                iss_row;
    fpqs_pkg::t_tag                                iss_tag;

    logic                     sum_valid, sum_ready;
    logic signed [SUM_W-1:0]  sum_val;
    logic [SAMPLE_WIDTH-1:0]  sum_raw;
    fpqs_pkg::t_tag           sum_tag;

    logic [SAMPLE_WIDTH-1:0]  res_val;
    fpqs_pkg::t_tag           res_tag;

    fpqs_framer #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_sample    (i_in.sample),
        .i_frame_end (i_in.frame_end),
        .o_iss_valid (iss_valid),
        .i_iss_ready (iss_ready),
        .o_iss_v     (iss_v),
        .o_iss_row   (iss_row),
        .o_iss_tag   (iss_tag)
    );

    fpqs_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (iss_valid),
        .o_ready (iss_ready),
        .i_v     (iss_v),
        .i_row   (iss_row),
        .i_tag   (iss_tag),
        .o_valid (sum_valid),
        .i_ready (sum_ready),
        .o_sum   (sum_val),
        .o_raw   (sum_raw),
        .o_tag   (sum_tag)
    );

    fpqs_div35 #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_div35 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .o_ready (sum_ready),
        .i_sum   (sum_val),
        .i_raw   (sum_raw),
        .i_tag   (sum_tag),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_value (res_val),
        .o_tag   (res_tag)
    );

    assign o_out.smoothed    = $signed(res_val);
    assign o_out.result_last = res_tag.last;
    assign o_out.short_frame = res_tag.short_frm;
endmodule

>>> sim/tb_five_point_quadratic_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Five-point quadratic smoother testbench
// Drives framed samples through the valid/ready input channel in random bursts.
// Results are drawn through the output channel under a changing stall pattern.
// Every result word is checked against a cycle-free fit computed here on the
// original samples, including the end rows and the short-frame pass-through.
// ----------------------------------------------------------------------------
module tb_five_point_quadratic_smoother;

    localparam int SW          = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 16;
    localparam int RANDOM_WORDS = 470;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 frame_end;
    } t_sample_word;

    typedef struct {
        logic signed [SW-1:0] smoothed;
        logic                 result_last;
        logic                 short_frame;
    } t_smoothed_word;

    // Leading end rows, centered row, trailing end rows of the 5-point fit.
    localparam int FIT_ROWS [5][5] = '{
        '{ 31,  9, -3, -5,  3 },
        '{  9, 13, 12,  6, -5 },
        '{ -3, 12, 17, 12, -3 },
        '{ -5,  6, 12, 13,  9 },
        '{  3, -5, -3,  9, 31 }
    };

    logic i_clk;
    logic i_rst_n;

    fpqs_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
    fpqs_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

    five_point_quadratic_smoother #(
        .SAMPLE_WIDTH(SW)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_sample_word   samples_to_send [$];
    t_smoothed_word smoothed_due [$];

    logic signed [SW-1:0] history [4];
    int                   frame_pos;
    int                   error_count;
    int                   cycle_count;

    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_phase;
    int stall_span;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d (pending %0d)",
                 what, got, want, smoothed_due.size());
        error_count++;
    endtask

    // Weighted sum over one row, divided by 35 with round half away from zero, then saturated.
    function automatic logic signed [SW-1:0] fit_row(int row, longint taps [5]);
        longint acc;
        acc = 0;
        for (int k = 0; k < 5; k++) begin
            acc += longint'(FIT_ROWS[row][k]) * taps[k];
        end
        if (acc >= 0) begin
            acc = (acc + 17) / 35;
        end else begin
            acc = -((-acc + 17) / 35);
        end
        if (acc > longint'(S_MAX)) begin
            acc = longint'(S_MAX);
        end else if (acc < longint'(S_MIN)) begin
            acc = longint'(S_MIN);
        end
        return acc[SW-1:0];
    endfunction

    function automatic void expect_word(logic signed [SW-1:0] v, logic last, logic shrt);
        t_smoothed_word w;
        w.smoothed    = v;
        w.result_last = last;
        w.short_frame = shrt;
        smoothed_due.push_back(w);
    endfunction

    function automatic void shift_history(logic signed [SW-1:0] x);
        history[0] = history[1];
        history[1] = history[2];
        history[2] = history[3];
        history[3] = x;
    endfunction

    // Works out the result words that one accepted sample word causes.
    function automatic void smooth_sample(logic signed [SW-1:0] x, logic fend);
        longint taps [5];
        if (frame_pos < 4) begin
            if (fend) begin
                for (int k = 4 - frame_pos; k < 4; k++) begin
                    expect_word(history[k], 1'b0, 1'b1);
                end
                expect_word(x, 1'b1, 1'b1);
                frame_pos = 0;
            end else begin
                shift_history(x);
                frame_pos++;
            end
            return;
        end
        for (int k = 0; k < 4; k++) begin
            taps[k] = longint'(history[k]);
        end
        taps[4] = longint'(x);
        if (frame_pos == 4) begin
            expect_word(fit_row(0, taps), 1'b0, 1'b0);
            expect_word(fit_row(1, taps), 1'b0, 1'b0);
        end
        expect_word(fit_row(2, taps), 1'b0, 1'b0);
        if (fend) begin
            expect_word(fit_row(3, taps), 1'b0, 1'b0);
            expect_word(fit_row(4, taps), 1'b1, 1'b0);
            frame_pos = 0;
        end else begin
            shift_history(x);
            frame_pos = 5;
        end
    endfunction

    function automatic void queue_word(logic signed [SW-1:0] s, logic fend);
        t_sample_word w;
        w.sample    = s;
        w.frame_end = fend;
        samples_to_send.push_back(w);
    endfunction

    function automatic logic signed [SW-1:0] pick_sample(int style, int idx);
        int roll;
        roll = $urandom_range(0, 99);
        case (style)
            1: begin
                // Alternating rails, with random words mixed in, drive the end rows and center row at full scale.
                if (roll < 80) return (idx % 2) ? S_MAX : S_MIN;
                return SW'($urandom_range(0, 65535));
            end
            2: return SW'($urandom_range(0, 100) - 50);
            default: begin
                if (roll < 10) return S_MAX;
                if (roll < 20) return S_MIN;
                if (roll < 30) return SW'($urandom_range(0, 40) - 20);
                return SW'($urandom_range(0, 65535));
            end
        endcase
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        t_sample_word w;
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.sample    <= '0;
            in_ch.frame_end <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                smooth_sample(in_ch.sample, in_ch.frame_end);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (samples_to_send.size() > 0) begin
                    w = samples_to_send.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.sample    <= w.sample;
                    in_ch.frame_end <= w.frame_end;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word and changes its stall pattern now and then.
    always @(posedge i_clk) begin
        t_smoothed_word want;
        logic           rdy;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (smoothed_due.size() == 0) begin
                    $display("UNEXPECTED result word: smoothed %0d last %0b short %0b",
                             out_ch.smoothed, out_ch.result_last, out_ch.short_frame);
                    error_count++;
                end else begin
                    want = smoothed_due.pop_front();
                    if (out_ch.smoothed !== want.smoothed) begin
                        report_mismatch("smoothed", int'(out_ch.smoothed),
                                        int'(want.smoothed));
                    end
                    if (out_ch.result_last !== want.result_last) begin
                        report_mismatch("result_last", int'(out_ch.result_last),
                                        int'(want.result_last));
                    end
                    if (out_ch.short_frame !== want.short_frame) begin
                        report_mismatch("short_frame", int'(out_ch.short_frame),
                                        int'(want.short_frame));
                    end
                end
            end
            stall_phase++;
            if (stall_phase >= stall_span) begin
                stall_phase = 0;
                stall_span  = $urandom_range(50, 200);
                stall_mode  = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       rdy = 1'b1;
                1:       rdy = 1'($urandom_range(0, 1));
                2:       rdy = (stall_phase % 4) == 0;
                default: rdy = (stall_phase % 24) >= 20;
            endcase
            out_ch.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_five_point_quadratic_smoother: done, errors");
        $finish;
    end

    initial begin
        int words;
        int len;
        int style;
        int roll;

        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.sample    = '0;
        in_ch.frame_end = 1'b0;
        out_ch.ready    = 1'b0;
        error_count     = 0;
        cycle_count     = 0;
        frame_pos       = 0;
        for (int k = 0; k < 4; k++) begin
            history[k] = '0;
        end
        burst_left  = $urandom_range(1, 40);
        gap_left    = 0;
        stall_mode  = 0;
        stall_phase = 0;
        stall_span  = 60;

        // Short frames of every length, each returned unchanged.
        queue_word(S_MAX, 1'b1);
        queue_word(S_MIN, 1'b0);
        queue_word(16'sd1, 1'b1);
        queue_word(16'sd21845, 1'b0);
        queue_word(-16'sd21846, 1'b0);
        queue_word(-16'sd1, 1'b1);
        queue_word(16'sd1, 1'b0);
        queue_word(-16'sd1, 1'b0);
        queue_word(S_MAX, 1'b0);
        queue_word(S_MIN, 1'b1);
        // Minimum full frame, leading end row pushed past the upper rail.
        queue_word(S_MAX, 1'b0);
        queue_word(S_MAX, 1'b0);
        queue_word(S_MIN, 1'b0);
        queue_word(S_MIN, 1'b0);
        queue_word(S_MAX, 1'b1);
        // Six-sample frame whose centered row saturates high.
        queue_word(S_MIN, 1'b0);
        queue_word(S_MAX, 1'b0);
        queue_word(S_MAX, 1'b0);
        queue_word(S_MAX, 1'b0);
        queue_word(S_MIN, 1'b0);
        queue_word(S_MIN, 1'b1);

        words = 0;
        while (words < RANDOM_WORDS) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                len = $urandom_range(1, 4);
            end else if (roll < 25) begin
                len = 5;
            end else if (roll < 33) begin
                len = $urandom_range(30, 60);
            end else begin
                len = $urandom_range(6, 20);
            end
            roll  = $urandom_range(0, 99);
            style = (roll < 15) ? 1 : (roll < 30) ? 2 : 0;
            for (int i = 0; i < len; i++) begin
                queue_word(pick_sample(style, i), i == len - 1);
            end
            words += len;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (samples_to_send.size() != 0 || in_ch.valid) begin
            @(posedge i_clk);
        end
        while (smoothed_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_five_point_quadratic_smoother: done, clean");
        end else begin
            $display("tb_five_point_quadratic_smoother: done, errors");
        end
        $finish;
    end

endmodule
